>>> rtl/bevr_pkg.sv
// shared constants, codes and types of the bird's-eye-view point rasterizer
package bevr_pkg;

  localparam int MAX_SIDE      = 256;
  localparam int COORD_BITS    = 24;
  localparam int IDX_BITS      = $clog2(MAX_SIDE);
  localparam int ADDR_BITS     = 2 * IDX_BITS;
  localparam int STORE_DEPTH   = MAX_SIDE * MAX_SIDE;
  localparam int SIDE_BITS     = 9;
  localparam int CPM_BITS      = 16;
  localparam int PIX_BITS      = 8;
  localparam int PADDR_BITS    = 16;
  localparam int INT_BITS      = 8;
  localparam int DIFF_BITS     = COORD_BITS + 1;
  localparam int PROD_BITS     = DIFF_BITS + CPM_BITS + 1;
  localparam int FRAC_SHIFT    = 16;
  localparam int CELL_BITS     = PROD_BITS - FRAC_SHIFT;
  localparam int LIN_BITS      = IDX_BITS + SIDE_BITS;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = (COORD_BITS > CPM_BITS) ? COORD_BITS : CPM_BITS;

  localparam logic [CPM_BITS-1:0]  CPM_RESET  = CPM_BITS'(256);
  localparam logic [SIDE_BITS-1:0] SIDE_RESET = SIDE_BITS'(256);
  localparam logic [PIX_BITS-1:0]  PIX_SAT    = '1;

  typedef enum logic [1:0] {
    KIND_ACC   = 2'd0,
    KIND_READ  = 2'd1,
    KIND_CLEAR = 2'd2,
    KIND_NONE  = 2'd3
  } kind_e;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_ORIGIN_X  = 3'd0,
    REG_ORIGIN_Y  = 3'd1,
    REG_CPM       = 3'd2,
    REG_GRID_H    = 3'd3,
    REG_GRID_W    = 3'd4,
    REG_USE_INTEN = 3'd5
  } cfg_reg_e;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_READ,
    S_RESP,
    S_ZERO,
    S_MUL,
    S_IDX,
    S_ADDR,
    S_FETCH,
    S_UPDATE
  } state_e;

endpackage

>>> rtl/bevr_ram.sv
// generic single-clock ram, one write port and one registered read port
module bevr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

>>> rtl/bev_point_rasterizer.sv
// bird's-eye-view point rasterizer top level with pixel store and control
// accumulate: busy after acceptance through the multiply, index, address, fetch and update states
// read: busy through the read and response states, result strobe in the response state
// clear: busy in the zero state; unknown kind: busy stays low, the store and the state do not change
// the pixel store has one read and one write port; one beat is in flight at a time
// after reset busy stays high while every address of the store is swept to zero
module bev_point_rasterizer
  import bevr_pkg::*;
(
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0]      cfg_addr_i,
  input  logic [CFG_DATA_BITS-1:0]     cfg_wdata_i,
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   kind_i,
  input  logic signed [COORD_BITS-1:0] point_x_i,
  input  logic signed [COORD_BITS-1:0] point_y_i,
  input  logic [INT_BITS-1:0]          intensity_i,
  input  logic [PADDR_BITS-1:0]        pixel_addr_i,
  output logic                         result_valid_o,
  output logic [PIX_BITS-1:0]          pixel_value_o,
  output logic [PADDR_BITS-1:0]        pixel_index_o
);

  state_e state_q, state_d;

  logic signed [COORD_BITS-1:0] origin_x_q, origin_y_q;
  logic [CPM_BITS-1:0]          cpm_q;
  logic [SIDE_BITS-1:0]         grid_h_q, grid_w_q;
  logic                         use_inten_q;

  logic [ADDR_BITS-1:0]        init_cnt_q;
  logic signed [DIFF_BITS-1:0] diff_x_q, diff_y_q;
  logic signed [PROD_BITS-1:0] prod_x_q, prod_y_q;
  logic signed [PROD_BITS-1:0] prod_x_d, prod_y_d;
  logic [IDX_BITS-1:0]         x_idx_q, y_idx_q;
  logic [ADDR_BITS-1:0]        pix_addr_q;
  logic [LIN_BITS-1:0]         lin_sum;
  logic [INT_BITS-1:0]         inten_q;
  logic [PADDR_BITS-1:0]       paddr_q;
  logic [SIDE_BITS-1:0]        side_h, side_w;
  logic                        accept;

  logic                 ram_we;
  logic [ADDR_BITS-1:0] ram_waddr, ram_raddr;
  logic [PIX_BITS-1:0]  ram_wdata, ram_rdata, upd_value;

  function automatic logic [SIDE_BITS-1:0] eff_side(logic [SIDE_BITS-1:0] s);
    logic [SIDE_BITS-1:0] r;
    if (s == '0) begin
      r = SIDE_BITS'(1);
    end else if (s > SIDE_BITS'(MAX_SIDE)) begin
      r = SIDE_BITS'(MAX_SIDE);
    end else begin
      r = s;
    end
    return r;
  endfunction

  // side minus truncated cell count, clamped to 0..side-1
  function automatic logic [IDX_BITS-1:0] cell_idx(logic signed [PROD_BITS-1:0] prod,
                                                   logic [SIDE_BITS-1:0] side);
    logic [CELL_BITS-1:0] cells;
    logic [IDX_BITS-1:0]  r;
    cells = prod[PROD_BITS-1:FRAC_SHIFT];
    if (prod[PROD_BITS-1] || cells == '0) begin
      r = IDX_BITS'(side - SIDE_BITS'(1));
    end else if (cells >= CELL_BITS'(side)) begin
      r = '0;
    end else begin
      r = IDX_BITS'(side - cells[SIDE_BITS-1:0]);
    end
    return r;
  endfunction

  assign accept = start && !busy;
  assign side_h = eff_side(grid_h_q);
  assign side_w = eff_side(grid_w_q);
  assign lin_sum = y_idx_q * side_w + x_idx_q;
  assign prod_x_d = diff_x_q * $signed({1'b0, cpm_q});
  assign prod_y_d = diff_y_q * $signed({1'b0, cpm_q});

  always_comb begin
    if (use_inten_q) begin
      upd_value = (inten_q > ram_rdata) ? inten_q : ram_rdata;
    end else begin
      upd_value = (ram_rdata == PIX_SAT) ? PIX_SAT : ram_rdata + PIX_BITS'(1);
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_x_q  <= '0;
      origin_y_q  <= '0;
      cpm_q       <= CPM_RESET;
      grid_h_q    <= SIDE_RESET;
      grid_w_q    <= SIDE_RESET;
      use_inten_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        REG_ORIGIN_X:  origin_x_q  <= cfg_wdata_i[COORD_BITS-1:0];
        REG_ORIGIN_Y:  origin_y_q  <= cfg_wdata_i[COORD_BITS-1:0];
        REG_CPM:       cpm_q       <= cfg_wdata_i[CPM_BITS-1:0];
        REG_GRID_H:    grid_h_q    <= cfg_wdata_i[SIDE_BITS-1:0];
        REG_GRID_W:    grid_w_q    <= cfg_wdata_i[SIDE_BITS-1:0];
        REG_USE_INTEN: use_inten_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_INIT;
      init_cnt_q <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == S_INIT) begin
        init_cnt_q <= init_cnt_q + ADDR_BITS'(1);
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (accept) begin
      diff_x_q <= DIFF_BITS'(point_x_i) - DIFF_BITS'(origin_x_q);
      diff_y_q <= DIFF_BITS'(point_y_i) - DIFF_BITS'(origin_y_q);
      inten_q  <= intensity_i;
      paddr_q  <= pixel_addr_i;
    end
    if (state_q == S_MUL) begin
      prod_x_q <= prod_x_d;
      prod_y_q <= prod_y_d;
    end
    if (state_q == S_IDX) begin
      x_idx_q <= cell_idx(prod_x_q, side_h);
      y_idx_q <= cell_idx(prod_y_q, side_w);
    end
    if (state_q == S_ADDR) begin
      pix_addr_q <= lin_sum[ADDR_BITS-1:0];
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_INIT: begin
        if (&init_cnt_q) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          unique case (kind_e'(kind_i))
            KIND_ACC:   state_d = S_MUL;
            KIND_READ:  state_d = S_READ;
            KIND_CLEAR: state_d = S_ZERO;
            KIND_NONE:  state_d = S_IDLE;
          endcase
        end
      end
      S_READ:   state_d = S_RESP;
      S_RESP:   state_d = S_IDLE;
      S_ZERO:   state_d = S_IDLE;
      S_MUL:    state_d = S_IDX;
      S_IDX:    state_d = S_ADDR;
      S_ADDR:   state_d = S_FETCH;
      S_FETCH:  state_d = S_UPDATE;
      S_UPDATE: state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  // outputs and store access
  always_comb begin
    busy           = (state_q != S_IDLE);
    result_valid_o = 1'b0;
    ram_we         = 1'b0;
    ram_waddr      = pix_addr_q;
    ram_wdata      = upd_value;
    ram_raddr      = pix_addr_q;
    unique case (state_q)
      S_INIT: begin
        ram_we    = 1'b1;
        ram_waddr = init_cnt_q;
        ram_wdata = '0;
      end
      S_READ: ram_raddr = ADDR_BITS'(paddr_q);
      S_RESP: result_valid_o = 1'b1;
      S_ZERO: begin
        ram_we    = 1'b1;
        ram_waddr = ADDR_BITS'(paddr_q);
        ram_wdata = '0;
      end
      S_UPDATE: ram_we = 1'b1;
      default: ;
    endcase
  end

  assign pixel_value_o = ram_rdata;
  assign pixel_index_o = paddr_q;

  bevr_ram #(
    .WIDTH(PIX_BITS),
    .DEPTH(STORE_DEPTH)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  a_read_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && kind_i == KIND_READ |-> ##2 result_valid_o)
    else $error("read beat gave no result");

  a_read_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && kind_i == KIND_READ |-> ##2 (pixel_index_o == $past(pixel_addr_i, 2)))
    else $error("result index does not echo the read address");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(state_q == S_READ))
    else $error("result strobe without a read");

  a_write_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> busy)
    else $error("store written while idle");

  a_acc_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && kind_i == KIND_ACC |=> busy ##4 busy)
    else $error("accumulate beat released early");

endmodule
